FILE: src/nsf_pkg.sv
// Shared types and constants for the 3x3 neighbour subtract filter.
// No dependencies; imported by the filter top level.
`default_nettype none

package nsf_pkg;

  localparam int PIX_W       = 8;   // pixel field width
  localparam int VAL_W       = 12;  // filtered value width, two's complement
  localparam int ROW_W       = 12;  // row counter width (up to 4096 rows)
  localparam int CFG_W_BITS  = 11;  // frame_width register width
  localparam int CFG_H_BITS  = 13;  // frame_height register width
  localparam int CFG_DATA_W  = 13;  // widest register
  localparam int CFG_IDX_W   = 1;
  localparam int IN_DATA_W   = 8;
  localparam int OUT_DATA_W  = 16;

  localparam int FRAME_MIN   = 2;
  localparam int HEIGHT_MAX  = 4096;

  localparam int FIFO_DEPTH  = 4;
  localparam int FPTR_W      = 2;
  localparam int FCNT_W      = 3;

  localparam logic [CFG_IDX_W-1:0]  REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0]  REG_FRAME_HEIGHT = 1'b1;

  localparam logic [CFG_W_BITS-1:0] FRAME_WIDTH_RST  = 11'd64;
  localparam logic [CFG_H_BITS-1:0] FRAME_HEIGHT_RST = 13'd64;

  // Per-request control that travels down the pipe beside the pixel.
  typedef struct packed {
    logic emit;      // request produces a result
    logic top_ok;    // row above lies in the frame
    logic bot_ok;    // row below lies in the frame
    logic left_ok;   // column to the left lies in the frame
    logic right_ok;  // column to the right lies in the frame
    logic eof;       // result belongs to the last pixel of the frame
  } nsf_meta_t;

  typedef struct packed {
    logic             eof;
    logic [VAL_W-1:0] value;
  } nsf_out_t;

endpackage

`default_nettype wire

FILE: src/nsf_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Read-first: a read at the address being written returns the old word.
`default_nettype none

module nsf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

FILE: src/neighbour_subtract_filter_3x3.sv
// Top level of the 3x3 neighbour subtract filter: counters, line store
// read-modify-write, 3x3 window and output queue. Uses nsf_pkg and nsf_ram.
//
//   channel | dir | handshake            | payload
//   in_     | in  | in_tvalid/in_tready  | in_tdata: pixel, in_tuser: op
//   out_    | out | out_tvalid/out_tready| out_tdata: filtered_value, out_tlast: end_of_frame
//   cfg_    | in  | cfg_we               | cfg_index, cfg_wdata
//
// One request per cycle while in_tready is high. A result passes the s1 and
// s2 registers into the output queue, whose head shows on out_; the line
// store port does one read and one write per cycle. in_tready drops only while
// queued plus in-flight results fill the four-entry output queue.
// Reset is synchronous; the line store has no clearing pass.
`default_nettype none

module neighbour_subtract_filter_3x3 #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [nsf_pkg::IN_DATA_W-1:0]     in_tdata,   // [7:0] pixel
  input  wire logic                              in_tuser,   // [0] op
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic      [nsf_pkg::OUT_DATA_W-1:0]    out_tdata,  // [11:0] filtered_value
  output logic                                   out_tlast,  // end_of_frame
  input  wire logic                              cfg_we,
  input  wire logic [nsf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [nsf_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  import nsf_pkg::*;

  localparam int AW     = $clog2(MAX_WIDTH);
  localparam int WW     = $clog2(MAX_WIDTH + 1);
  localparam int LEAD_W = $clog2(MAX_WIDTH + 2);
  localparam int CMP_W  = ((WW > CFG_W_BITS) ? WW : CFG_W_BITS) + 1;

  // configuration
  logic [CFG_W_BITS-1:0] frame_width_r, frame_width_nxt;
  logic [CFG_H_BITS-1:0] frame_height_r, frame_height_nxt;
  logic [CMP_W-1:0]      fw_ext;
  logic [WW-1:0]         eff_w;
  logic [CFG_H_BITS-1:0] eff_h;
  logic [AW-1:0]         w_m1;
  logic [ROW_W-1:0]      h_m1;
  logic [LEAD_W-1:0]     w_p1;

  // stream counters
  logic [AW-1:0]     in_col_r, in_col_nxt, out_col_r, out_col_nxt;
  logic [ROW_W-1:0]  in_row_r, in_row_nxt, out_row_r, out_row_nxt;
  logic [LEAD_W-1:0] lead_r, lead_nxt;
  logic              draining_r, draining_nxt;

  // request decode
  logic              is_flush, flush_ok, take, restart_push;
  logic [LEAD_W-1:0] b_lead;
  logic [AW-1:0]     b_in_col, b_out_col, in_col_inc, out_col_inc;
  logic [ROW_W-1:0]  b_in_row, b_out_row, in_row_inc, out_row_inc;
  logic              st_emit;
  logic [AW-1:0]     st_addr;
  nsf_meta_t         st_meta;

  // line store stage
  logic              s1_valid_r;
  logic [AW-1:0]     s1_addr_r;
  logic [PIX_W-1:0]  s1_pix_r;
  nsf_meta_t         s1_meta_r;
  logic [2*PIX_W-1:0] ram_rdata, ram_wdata;
  logic              fwd_valid_r;
  logic [AW-1:0]     fwd_addr_r;
  logic [PIX_W-1:0]  fwd_up_r, fwd_mid_r;
  logic              fwd_hit;
  logic [PIX_W-1:0]  up_eff, mid_eff;
  logic [PIX_W-1:0]  win_r [3][3];

  // filter stage and output queue
  logic              s2_emit_r;
  nsf_meta_t         s2_meta_r;
  logic [2:0]        row_keep, col_keep;
  logic [VAL_W-1:0]  nb_sum, filt_value;
  nsf_out_t          fifo_r [FIFO_DEPTH];
  logic [FPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [FCNT_W-1:0] fifo_cnt_r, fifo_cnt_nxt;
  logic              fifo_pop;
  nsf_out_t          head;

  // effective frame size
  always_comb begin
    fw_ext = CMP_W'(frame_width_r);
    if (fw_ext < CMP_W'(FRAME_MIN)) begin
      eff_w = WW'(FRAME_MIN);
    end else if (fw_ext > CMP_W'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(fw_ext);
    end
    if (frame_height_r < CFG_H_BITS'(FRAME_MIN)) begin
      eff_h = CFG_H_BITS'(FRAME_MIN);
    end else if (frame_height_r > CFG_H_BITS'(HEIGHT_MAX)) begin
      eff_h = CFG_H_BITS'(HEIGHT_MAX);
    end else begin
      eff_h = frame_height_r;
    end
    w_m1 = AW'(eff_w - 1'b1);
    h_m1 = ROW_W'(eff_h - 1'b1);
    w_p1 = LEAD_W'(eff_w) + LEAD_W'(1);
  end

  // request decode and counter update
  always_comb begin
    is_flush     = in_tuser;
    flush_ok     = draining_r || ((lead_r != '0) && (in_col_r == '0) && (in_row_r == '0));
    take         = in_tvalid && in_tready && (!is_flush || flush_ok);
    // a pixel during a drain starts a new frame
    restart_push = !is_flush && draining_r;
    b_lead       = restart_push ? '0 : lead_r;
    b_in_col     = restart_push ? '0 : in_col_r;
    b_in_row     = restart_push ? '0 : in_row_r;
    b_out_col    = restart_push ? '0 : out_col_r;
    b_out_row    = restart_push ? '0 : out_row_r;
    in_col_inc   = (b_in_col == w_m1) ? '0 : b_in_col + 1'b1;
    in_row_inc   = (b_in_row == h_m1) ? '0 : b_in_row + 1'b1;
    out_col_inc  = (b_out_col == w_m1) ? '0 : b_out_col + 1'b1;
    out_row_inc  = (b_out_row == h_m1) ? '0 : b_out_row + 1'b1;

    st_emit          = is_flush || (b_lead >= w_p1);
    st_addr          = is_flush ? out_col_inc : b_in_col;
    st_meta.emit     = st_emit;
    st_meta.top_ok   = (b_out_row != '0);
    st_meta.bot_ok   = (b_out_row != h_m1);
    st_meta.left_ok  = (b_out_col != '0);
    st_meta.right_ok = (b_out_col != w_m1);
    st_meta.eof      = (b_out_col == w_m1) && (b_out_row == h_m1);

    frame_width_nxt  = frame_width_r;
    frame_height_nxt = frame_height_r;
    in_col_nxt       = in_col_r;
    in_row_nxt       = in_row_r;
    out_col_nxt      = out_col_r;
    out_row_nxt      = out_row_r;
    lead_nxt         = lead_r;
    draining_nxt     = draining_r;

    if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width_nxt  = cfg_wdata[CFG_W_BITS-1:0];
        REG_FRAME_HEIGHT: frame_height_nxt = cfg_wdata[CFG_H_BITS-1:0];
      endcase
      in_col_nxt   = '0;
      in_row_nxt   = '0;
      out_col_nxt  = '0;
      out_row_nxt  = '0;
      lead_nxt     = '0;
      draining_nxt = 1'b0;
    end else if (take) begin
      if (st_emit) begin
        out_col_nxt = out_col_inc;
        out_row_nxt = (b_out_col == w_m1) ? out_row_inc : b_out_row;
      end else begin
        out_col_nxt = b_out_col;
        out_row_nxt = b_out_row;
      end
      if (is_flush) begin
        if (lead_r == LEAD_W'(1)) begin
          // last pending result: back to the start of a frame
          in_col_nxt   = '0;
          in_row_nxt   = '0;
          out_col_nxt  = '0;
          out_row_nxt  = '0;
          lead_nxt     = '0;
          draining_nxt = 1'b0;
        end else begin
          lead_nxt     = lead_r - 1'b1;
          draining_nxt = 1'b1;
        end
      end else begin
        lead_nxt     = st_emit ? b_lead : b_lead + 1'b1;
        in_col_nxt   = in_col_inc;
        in_row_nxt   = (b_in_col == w_m1) ? in_row_inc : b_in_row;
        draining_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FRAME_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
      in_col_r       <= '0;
      in_row_r       <= '0;
      out_col_r      <= '0;
      out_row_r      <= '0;
      lead_r         <= '0;
      draining_r     <= 1'b0;
      s1_valid_r     <= 1'b0;
    end else begin
      frame_width_r  <= frame_width_nxt;
      frame_height_r <= frame_height_nxt;
      in_col_r       <= in_col_nxt;
      in_row_r       <= in_row_nxt;
      out_col_r      <= out_col_nxt;
      out_row_r      <= out_row_nxt;
      lead_r         <= lead_nxt;
      draining_r     <= draining_nxt;
      s1_valid_r     <= take && !cfg_we;
    end
  end

  always_ff @(posedge clk) begin
    s1_addr_r <= st_addr;
    s1_pix_r  <= is_flush ? '0 : in_tdata[PIX_W-1:0];
    s1_meta_r <= st_meta;
  end

  // line store: upper row in the high half, middle row in the low half
  nsf_ram #(
    .WIDTH (2 * PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (s1_valid_r),
    .waddr (s1_addr_r),
    .wdata (ram_wdata),
    .raddr (st_addr),
    .rdata (ram_rdata)
  );

  // the previous request wrote this entry on the edge our read was taken
  always_comb begin
    fwd_hit   = fwd_valid_r && (fwd_addr_r == s1_addr_r);
    up_eff    = fwd_hit ? fwd_up_r  : ram_rdata[2*PIX_W-1:PIX_W];
    mid_eff   = fwd_hit ? fwd_mid_r : ram_rdata[PIX_W-1:0];
    ram_wdata = {mid_eff, s1_pix_r};
  end

  always_ff @(posedge clk) begin
    fwd_addr_r <= s1_addr_r;
    fwd_up_r   <= mid_eff;
    fwd_mid_r  <= s1_pix_r;
    s2_meta_r  <= s1_meta_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_valid_r <= 1'b0;
      s2_emit_r   <= 1'b0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_r[r][c] <= '0;
        end
      end
    end else begin
      fwd_valid_r <= s1_valid_r;
      s2_emit_r   <= s1_valid_r && s1_meta_r.emit;
      if (s1_valid_r) begin
        // shift left, new column on the right
        for (int r = 0; r < 3; r++) begin
          win_r[r][0] <= win_r[r][1];
          win_r[r][1] <= win_r[r][2];
        end
        win_r[0][2] <= up_eff;
        win_r[1][2] <= mid_eff;
        win_r[2][2] <= s1_pix_r;
      end
    end
  end

  // centre minus the in-frame neighbours; centre sits in the middle column
  always_comb begin
    row_keep = {s2_meta_r.bot_ok, 1'b1, s2_meta_r.top_ok};
    col_keep = {s2_meta_r.right_ok, 1'b1, s2_meta_r.left_ok};
    nb_sum   = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (row_keep[r] && col_keep[c] && !((r == 1) && (c == 1))) begin
          nb_sum = nb_sum + VAL_W'(win_r[r][c]);
        end
      end
    end
    filt_value = VAL_W'(win_r[1][1]) - nb_sum;
  end

  // output queue
  assign head       = fifo_r[rd_ptr_r];
  assign out_tvalid = (fifo_cnt_r != '0);
  assign out_tdata  = OUT_DATA_W'(head.value);
  assign out_tlast  = head.eof;
  assign fifo_pop   = out_tvalid && out_tready;
  assign in_tready  = (fifo_cnt_r + FCNT_W'(s1_valid_r && s1_meta_r.emit)
                       + FCNT_W'(s2_emit_r)) < FCNT_W'(FIFO_DEPTH);

  always_comb begin
    fifo_cnt_nxt = fifo_cnt_r + FCNT_W'(s2_emit_r) - FCNT_W'(fifo_pop);
  end

  always_ff @(posedge clk) begin
    if (s2_emit_r) begin
      fifo_r[wr_ptr_r] <= '{eof: s2_meta_r.eof, value: filt_value};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      fifo_cnt_r <= '0;
    end else begin
      if (s2_emit_r) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (fifo_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      fifo_cnt_r <= fifo_cnt_nxt;
    end
  end

  // checks
  a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_cnt_r <= FCNT_W'(FIFO_DEPTH))
    else $error("output queue count above depth");

  a_fifo_room: assert property (@(posedge clk) disable iff (!rst_n)
    s2_emit_r |-> (fifo_cnt_r < FCNT_W'(FIFO_DEPTH)) || fifo_pop)
    else $error("result pushed into a full output queue");

  a_drain_pos: assert property (@(posedge clk) disable iff (!rst_n)
    draining_r |-> ((in_col_r == '0) && (in_row_r == '0)))
    else $error("drain under way away from frame start");

  a_lead_bound: assert property (@(posedge clk) disable iff (!rst_n)
    lead_r <= w_p1)
    else $error("pending result count above one row plus one");

endmodule

`default_nettype wire
